FILE: sv/layer_priority_pixel_compositor_core_defines.svh
// assertion macros for the pixel compositor
`ifndef LAYER_PRIORITY_PIXEL_COMPOSITOR_CORE_DEFINES_SVH
`define LAYER_PRIORITY_PIXEL_COMPOSITOR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LPPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lppc assertion failed");
`define LPPC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lppc assertion failed");
`else
`define LPPC_ASSERT(lbl, prop)
`define LPPC_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

FILE: sv/lppc_pkg.sv
package lppc_pkg;

  localparam int LPPC_LINE_DEPTH  = 512;
  localparam int LPPC_LINE_TABLES = 3;
  localparam int LPPC_LAYER_COUNT = 6;
  localparam int LPPC_Q_DEPTH     = 4;

  localparam logic [2:0]  BACK_ID       = 3'd6;
  localparam logic [1:0]  SHADOW_NORMAL = 2'd1;
  localparam logic [1:0]  SHADOW_MSB    = 2'd2;
  localparam logic        OP_ENTRY      = 1'b0;
  localparam logic        OP_LINE_WRITE = 1'b1;
  localparam logic        REG_BLEND_MODE = 1'b0;
  localparam logic        REG_SPRITE_WIN = 1'b1;
  localparam logic [31:0] SHADOW_COLOR  = 32'h2000_0000;

  typedef enum logic [1:0] {
    MODE_TOP    = 2'd0,
    MODE_BOTTOM = 2'd1,
    MODE_ADD    = 2'd2
  } mode_e;

  typedef struct packed {
    logic [31:0] color;
    logic [2:0]  prio;
    logic [2:0]  layer;
    logic [1:0]  line_sel;
    logic [1:0]  kind;
    logic        shadow;
  } entry_t;

  typedef struct packed {
    logic        is_write;
    logic [31:0] color;
    logic [1:0]  line_sel;
    logic [1:0]  kind;
    logic [31:0] s1_color;
    logic        s1_shadow;
    logic [8:0]  line_y;
  } job_t;

  // floor(x / 255) for x below 65535
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] s;
    logic [16:0] r;
    s = 17'(x) + 17'd1;
    r = (s + (s >> 8)) >> 8;
    return r[7:0];
  endfunction

  function automatic logic [7:0] mix8(logic [7:0] t, logic [7:0] b, logic [7:0] a);
    logic [8:0] sum;
    sum = 9'(div255(16'(t) * 16'(a))) + 9'(div255(16'(b) * 16'(8'hFF - a)));
    return sum[7:0];
  endfunction

  function automatic logic [31:0] blend(logic [1:0] mode, logic [31:0] top,
                                        logic [31:0] bot);
    logic [7:0] a;
    logic [8:0] r;
    logic [8:0] g;
    logic [8:0] b;
    logic [31:0] res;
    r = 9'(top[23:16]) + 9'(bot[23:16]);
    g = 9'(top[15:8]) + 9'(bot[15:8]);
    b = 9'(top[7:0]) + 9'(bot[7:0]);
    unique case (mode)
      MODE_BOTTOM: begin
        a = {bot[29:24], 2'b11};
        if (!top[31]) begin
          res = top;
        end else begin
          res = {2'b00, top[29:24], mix8(top[23:16], bot[23:16], a),
                 mix8(top[15:8], bot[15:8], a), mix8(top[7:0], bot[7:0], a)};
        end
      end
      MODE_ADD: begin
        a = 8'd0;
        res = {8'h3F, r[8] ? 8'hFF : r[7:0], g[8] ? 8'hFF : g[7:0],
               b[8] ? 8'hFF : b[7:0]};
      end
      default: begin
        a = {top[29:24], 2'b11};
        res = {8'h3F, mix8(top[23:16], bot[23:16], a),
               mix8(top[15:8], bot[15:8], a), mix8(top[7:0], bot[7:0], a)};
      end
    endcase
    return res;
  endfunction

  function automatic logic is_trans(logic [1:0] mode, logic [31:0] p);
    logic t;
    if (mode == MODE_BOTTOM || mode == MODE_ADD) begin
      t = p[31];
    end else begin
      t = (p[29:24] != 6'h3F);
    end
    return t;
  endfunction

endpackage

FILE: sv/lppc_fifo.sv
module lppc_fifo
  import lppc_pkg::*;
#(
  parameter int Depth = LPPC_Q_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wr_data_i,
  input  logic rd_i,
  output job_t rd_data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  job_t          mem_q [Depth];
  logic [PW-1:0] wptr_q, wptr_d;
  logic [PW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == CW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_i) begin
      wptr_d = (wptr_q == PW'(Depth - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (rd_i) begin
      rptr_d = (rptr_q == PW'(Depth - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: sv/lppc_front.sv
module lppc_front
  import lppc_pkg::*;
#(
  parameter int LayerCount = LPPC_LAYER_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        opcode_i,
  input  entry_t      entry_i,
  input  logic [8:0]  line_y_i,
  input  logic        last_entry_i,
  output logic        job_valid_o,
  output job_t        job_o
);

  entry_t     first_q, first_d;
  entry_t     second_q, second_d;
  entry_t     back_q, back_d;
  logic [1:0] filled_q, filled_d;
  entry_t     s0, s1;
  logic [5:0] key_e;
  logic       take;

  assign key_e = {entry_i.prio, entry_i.layer};
  assign take  = (opcode_i == OP_ENTRY) && (entry_i.layer != BACK_ID) &&
                 ({1'b0, entry_i.layer} < 4'(LayerCount)) && (entry_i.prio != 3'd0);

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    back_d   = back_q;
    filled_d = filled_q;
    if (opcode_i == OP_ENTRY && entry_i.layer == BACK_ID) begin
      back_d = entry_i;
    end
    if (take) begin
      unique case (filled_q)
        2'd0: begin
          first_d  = entry_i;
          filled_d = 2'd1;
        end
        2'd1: begin
          if (key_e > {first_q.prio, first_q.layer}) begin
            second_d = first_q;
            first_d  = entry_i;
          end else begin
            second_d = entry_i;
          end
          filled_d = 2'd2;
        end
        default: begin
          if (key_e > {first_q.prio, first_q.layer}) begin
            second_d = first_q;
            first_d  = entry_i;
          end else if (key_e > {second_q.prio, second_q.layer}) begin
            second_d = entry_i;
          end
        end
      endcase
    end
    // pick the two surfaces that take part in the final dot
    priority if (filled_d >= 2'd2) begin
      s0 = first_d;
      s1 = second_d;
    end else if (filled_d == 2'd1) begin
      s0 = first_d;
      s1 = back_d;
    end else begin
      s0 = back_d;
      s1 = '0;
    end
  end

  always_comb begin
    job_valid_o = accept_i && ((opcode_i == OP_LINE_WRITE) || last_entry_i);
    job_o.is_write = (opcode_i == OP_LINE_WRITE);
    job_o.line_y   = line_y_i;
    if (opcode_i == OP_LINE_WRITE) begin
      job_o.color     = entry_i.color;
      job_o.line_sel  = entry_i.line_sel;
      job_o.kind      = 2'd0;
      job_o.s1_color  = '0;
      job_o.s1_shadow = 1'b0;
    end else begin
      job_o.color     = s0.color;
      job_o.line_sel  = s0.line_sel;
      job_o.kind      = s0.kind;
      job_o.s1_color  = s1.color;
      job_o.s1_shadow = s1.shadow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      back_q   <= '0;
      filled_q <= 2'd0;
    end else if (accept_i && opcode_i == OP_ENTRY) begin
      if (last_entry_i) begin
        first_q  <= '0;
        second_q <= '0;
        back_q   <= '0;
        filled_q <= 2'd0;
      end else begin
        first_q  <= first_d;
        second_q <= second_d;
        back_q   <= back_d;
        filled_q <= filled_d;
      end
    end
  end

endmodule

FILE: sv/lppc_back.sv
module lppc_back
  import lppc_pkg::*;
#(
  parameter int LineDepth  = LPPC_LINE_DEPTH,
  parameter int LineTables = LPPC_LINE_TABLES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  blend_mode_i,
  input  logic        sprite_win_i,
  input  logic        job_avail_i,
  input  job_t        job_i,
  output logic        job_take_o,
  output logic        clearing_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [31:0] dot_color_o
);

  localparam int MemDepth = LineDepth * LineTables;
  localparam int AW = $clog2(MemDepth);

  logic [31:0]   mem_q [MemDepth];
  logic [AW-1:0] clr_cnt_q;
  logic          clr_q;
  logic          adv;
  logic          sel_ok, y_ok;
  logic [AW-1:0] addr;
  logic [1:0]    sel_m1;

  // stage a: line colour read
  logic        a_v_q;
  logic [31:0] a_rd_q;
  logic        a_zero_q;
  job_t        a_job_q;
  logic        a_blend_q;
  // stage b: after line-screen blend
  logic        b_v_q;
  logic [31:0] b_px_q;
  logic [1:0]  b_kind_q;
  logic [31:0] b_s1c_q;
  logic        b_s1sh_q;
  // stage c: before shadow
  logic        c_v_q;
  logic [31:0] c_px_q;
  logic        c_sh_q;
  // stage d: output
  logic        d_v_q;
  logic [31:0] d_px_q;

  logic [31:0] lc, px1, px2, trans_px;
  logic        sh;

  assign adv        = !d_v_q || pop_i;
  assign job_take_o = adv && job_avail_i && !clr_q;
  assign clearing_o = clr_q;
  assign empty_o    = !d_v_q;
  assign dot_color_o = d_px_q;

  assign sel_ok = (job_i.line_sel != 2'd0) && ({1'b0, job_i.line_sel} <= 3'(LineTables));
  assign y_ok   = (11'(job_i.line_y) < 11'(LineDepth));
  assign sel_m1 = job_i.line_sel - 2'd1;
  assign addr   = AW'(32'(sel_m1) * 32'(LineDepth) + 32'(job_i.line_y));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      if (clr_cnt_q == AW'(MemDepth - 1)) begin
        clr_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (job_take_o && job_i.is_write && sel_ok && y_ok) begin
      mem_q[addr] <= job_i.color;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      a_rd_q <= mem_q[addr];
    end
  end

  always_comb begin
    lc  = a_zero_q ? 32'd0 : a_rd_q;
    px1 = a_blend_q ? blend(blend_mode_i, a_job_q.color, lc) : a_job_q.color;
  end

  always_comb begin
    trans_px = is_trans(blend_mode_i, b_px_q) ? blend(blend_mode_i, b_px_q, b_s1c_q)
                                              : b_px_q;
    priority if ((b_kind_q == SHADOW_MSB && b_px_q[23:0] == 24'd0) ||
                 b_kind_q == SHADOW_NORMAL) begin
      px2 = b_s1c_q;
      sh  = b_s1sh_q;
    end else if (b_kind_q == SHADOW_MSB) begin
      px2 = trans_px;
      sh  = !sprite_win_i;
    end else begin
      px2 = trans_px;
      sh  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q <= job_take_o && !job_i.is_write;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_job_q   <= job_i;
      a_zero_q  <= !(sel_ok && y_ok);
      a_blend_q <= sel_ok;
      b_px_q    <= px1;
      b_kind_q  <= a_job_q.kind;
      b_s1c_q   <= a_job_q.s1_color;
      b_s1sh_q  <= a_job_q.s1_shadow;
      c_px_q    <= px2;
      c_sh_q    <= sh;
      d_px_q    <= c_sh_q ? blend(MODE_TOP, SHADOW_COLOR, c_px_q) : c_px_q;
    end
  end

endmodule

FILE: sv/layer_priority_pixel_compositor_core.sv
// layer priority pixel compositor: ranks layer entries per dot and shades the winner
// throughput: one item per cycle while full is low, set by the four-stage blend pipeline and line memory port
// reset: async active low; then a clearing pass over all LINE_TABLES*LINE_DEPTH words
//   (1536 by default) zeroes the line colour memory while full stays high
`include "layer_priority_pixel_compositor_core_defines.svh"
module layer_priority_pixel_compositor_core
  import lppc_pkg::*;
#(
  parameter int LINE_DEPTH  = LPPC_LINE_DEPTH,
  parameter int LINE_TABLES = LPPC_LINE_TABLES,
  parameter int LAYER_COUNT = LPPC_LAYER_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item channel
  input  logic        push,
  output logic        full,
  input  logic        opcode_i,
  input  logic [31:0] entry_color_i,
  input  logic [2:0]  entry_priority_i,
  input  logic [2:0]  layer_id_i,
  input  logic [1:0]  line_select_i,
  input  logic [1:0]  shadow_kind_i,
  input  logic        shadow_on_i,
  input  logic [8:0]  line_y_i,
  input  logic        last_entry_i,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [31:0] dot_color_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] blend_mode_q;
  logic       sprite_win_q;
  logic       accept;
  entry_t     entry;
  logic       job_valid;
  job_t       job, head;
  logic       q_full, q_empty, q_take;
  logic       clearing;

  // register file: blend mode at 0x0, sprite window at 0x4
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_BLEND_MODE: prdata = {30'd0, blend_mode_q};
      default:        prdata = {31'd0, sprite_win_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_mode_q <= 2'd0;
      sprite_win_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_BLEND_MODE) begin
        blend_mode_q <= pwdata[1:0];
      end else begin
        sprite_win_q <= pwdata[0];
      end
    end
  end

  // items are held off while the line memory is cleared or the job queue is full
  assign full   = q_full || clearing;
  assign accept = push && !full;

  assign entry.color    = entry_color_i;
  assign entry.prio     = entry_priority_i;
  assign entry.layer    = layer_id_i;
  assign entry.line_sel = line_select_i;
  assign entry.kind     = shadow_kind_i;
  assign entry.shadow   = shadow_on_i;

  // front: slot ranking, emits one job per line write or finished dot
  lppc_front #(
    .LayerCount(LAYER_COUNT)
  ) u_front (
    .clk_i,
    .rst_ni,
    .accept_i     (accept),
    .opcode_i,
    .entry_i      (entry),
    .line_y_i,
    .last_entry_i,
    .job_valid_o  (job_valid),
    .job_o        (job)
  );

  // short queue decouples the ranking front from the blend pipeline
  lppc_fifo #(
    .Depth(LPPC_Q_DEPTH)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .wr_i      (job_valid),
    .wr_data_i (job),
    .rd_i      (q_take),
    .rd_data_o (head),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  // back: line memory plus blend and shadow stages; last stage is the output register
  lppc_back #(
    .LineDepth (LINE_DEPTH),
    .LineTables(LINE_TABLES)
  ) u_back (
    .clk_i,
    .rst_ni,
    .blend_mode_i (blend_mode_q),
    .sprite_win_i (sprite_win_q),
    .job_avail_i  (!q_empty),
    .job_i        (head),
    .job_take_o   (q_take),
    .clearing_o   (clearing),
    .pop_i        (pop),
    .empty_o      (empty),
    .dot_color_o
  );

  // no item slips in while the line memory is being cleared
  `LPPC_ASSERT_IMPL(a_clear_blocks_input, clearing, full)
  // the clearing pass runs only with an empty pipeline
  `LPPC_ASSERT_IMPL(a_clear_no_result, clearing, empty)
  // jobs only leave the queue when it holds one
  `LPPC_ASSERT_IMPL(a_take_nonempty, q_take, !q_empty)

endmodule

FILE: dv/layer_priority_pixel_compositor_core_checker.sv
`timescale 1ns / 1ps
module layer_priority_pixel_compositor_core_checker
  import lppc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic        opcode_i,
  input  logic [31:0] entry_color_i,
  input  logic [2:0]  entry_priority_i,
  input  logic [2:0]  layer_id_i,
  input  logic [1:0]  line_select_i,
  input  logic [1:0]  shadow_kind_i,
  input  logic        shadow_on_i,
  input  logic [8:0]  line_y_i,
  input  logic        last_entry_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] dot_color_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          dots_waiting_o
);

  logic [31:0] line_mem [LPPC_LINE_TABLES*LPPC_LINE_DEPTH];
  entry_t      top_ent, next_ent, back_ent;
  int          ranked;
  logic [1:0]  mode_q;
  logic        sprite_win_q;
  logic [31:0] dot_q [$];

  assign dots_waiting_o = dot_q.size();

  function automatic logic [7:0] mix_chan(logic [7:0] t, logic [7:0] b, int a);
    return 8'((int'(t) * a) / 255 + (int'(b) * (255 - a)) / 255);
  endfunction

  function automatic logic [31:0] alpha_over(logic [31:0] t, logic [31:0] b, int a,
                                             logic [5:0] al);
    return {2'b00, al, mix_chan(t[23:16], b[23:16], a), mix_chan(t[15:8], b[15:8], a),
            mix_chan(t[7:0], b[7:0], a)};
  endfunction

  function automatic logic [7:0] sat_add(logic [7:0] x, logic [7:0] y);
    int s;
    s = int'(x) + int'(y);
    return (s > 255) ? 8'hFF : 8'(s);
  endfunction

  function automatic logic [31:0] mix_px(logic [31:0] t, logic [31:0] b);
    if (mode_q == MODE_BOTTOM) begin
      if (!t[31]) return t;
      return alpha_over(t, b, int'(b[29:24]) * 4 + 3, t[29:24]);
    end
    if (mode_q == MODE_ADD)
      return {8'h3F, sat_add(t[23:16], b[23:16]), sat_add(t[15:8], b[15:8]),
              sat_add(t[7:0], b[7:0])};
    return alpha_over(t, b, int'(t[29:24]) * 4 + 3, 6'h3F);
  endfunction

  function automatic logic [31:0] darken(logic [31:0] b);
    return alpha_over(SHADOW_COLOR, b, int'(SHADOW_COLOR[29:24]) * 4 + 3, 6'h3F);
  endfunction

  function automatic logic see_through(logic [31:0] p);
    if (mode_q == MODE_BOTTOM || mode_q == MODE_ADD) return p[31];
    return p[29:24] != 6'h3F;
  endfunction

  function automatic logic [31:0] compose_dot(logic [8:0] y);
    entry_t      s0, s1;
    logic [31:0] px;
    s1 = '0;
    if (ranked >= 2) begin
      s0 = top_ent;
      s1 = next_ent;
    end else if (ranked == 1) begin
      s0 = top_ent;
      s1 = back_ent;
    end else begin
      s0 = back_ent;
    end
    px = s0.color;
    if (s0.line_sel != 0 && s0.line_sel <= LPPC_LINE_TABLES)
      px = mix_px(px, line_mem[(int'(s0.line_sel) - 1) * LPPC_LINE_DEPTH + int'(y)]);
    if (s0.kind == SHADOW_MSB && px[23:0] == 24'h0) begin
      px = s1.shadow ? darken(s1.color) : s1.color;
    end else if (s0.kind == SHADOW_MSB) begin
      if (see_through(px)) px = mix_px(px, s1.color);
      if (!sprite_win_q) px = darken(px);
    end else if (s0.kind == SHADOW_NORMAL) begin
      px = s1.shadow ? darken(s1.color) : s1.color;
    end else if (see_through(px)) begin
      px = mix_px(px, s1.color);
    end
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    entry_t      e;
    logic [31:0] got, want;
    if (!rst_ni) begin
      foreach (line_mem[i]) line_mem[i] = '0;
      top_ent = '0;
      next_ent = '0;
      back_ent = '0;
      ranked = 0;
      mode_q = MODE_TOP;
      sprite_win_q = 1'b0;
      fail_count_o = 0;
      dot_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_BLEND_MODE, 2'b00}) mode_q = pwdata[1:0];
        else if (paddr == {REG_SPRITE_WIN, 2'b00}) sprite_win_q = pwdata[0];
      end
      // result side first: a dot cannot leave in the cycle its last entry enters
      if (pop && !empty) begin
        got = dot_color_o;
        if (dot_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected dot %h", got);
        end else begin
          want = dot_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10) $display("dot_color mismatch: exp %h got %h", want, got);
          end
        end
      end
      if (push && !full) begin
        e = '{entry_color_i, entry_priority_i, layer_id_i, line_select_i, shadow_kind_i,
              shadow_on_i};
        if (opcode_i == OP_LINE_WRITE) begin
          if (e.line_sel != 0 && e.line_sel <= LPPC_LINE_TABLES && line_y_i < LPPC_LINE_DEPTH)
            line_mem[(int'(e.line_sel) - 1) * LPPC_LINE_DEPTH + int'(line_y_i)] = e.color;
        end else begin
          if (e.layer == BACK_ID) begin
            back_ent = e;
          end else if (e.layer < LPPC_LAYER_COUNT && e.prio != 0) begin
            // rank by priority then layer, earlier entry wins a full tie
            if (ranked == 0) begin
              top_ent = e;
              ranked = 1;
            end else if ({e.prio, e.layer} > {top_ent.prio, top_ent.layer}) begin
              next_ent = top_ent;
              top_ent = e;
              ranked = 2;
            end else if (ranked == 1 || {e.prio, e.layer} > {next_ent.prio, next_ent.layer}) begin
              next_ent = e;
              ranked = 2;
            end
          end
          if (last_entry_i) begin
            dot_q.push_back(compose_dot(line_y_i));
            top_ent = '0;
            next_ent = '0;
            back_ent = '0;
            ranked = 0;
          end
        end
      end
    end
  end

endmodule

FILE: dv/layer_priority_pixel_compositor_core_tb.sv
`timescale 1ns / 1ps
module layer_priority_pixel_compositor_core_tb;
  import lppc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        opcode_i = OP_ENTRY;
  logic [31:0] entry_color_i = '0;
  logic [2:0]  entry_priority_i = '0;
  logic [2:0]  layer_id_i = '0;
  logic [1:0]  line_select_i = '0;
  logic [1:0]  shadow_kind_i = '0;
  logic        shadow_on_i = 1'b0;
  logic [8:0]  line_y_i = '0;
  logic        last_entry_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] dot_color_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          dots_waiting;
  int          items_sent;

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  layer_priority_pixel_compositor_core dut (.*);

  layer_priority_pixel_compositor_core_checker u_checker (
    .fail_count_o  (fail_count),
    .dots_waiting_o(dots_waiting),
    .*
  );

  // result side: mostly ready, short stalls and an occasional long one
  initial begin
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 199) == 0) begin
        pop = 1'b0;
        repeat ($urandom_range(20, 60)) @(negedge clk_i);
      end else if ($urandom_range(0, 15) == 0) begin
        pop = 1'b1;
        repeat ($urandom_range(30, 80)) @(negedge clk_i);
      end else begin
        pop = ($urandom_range(0, 3) != 0);
      end
    end
  end

  // register write: setup then access phase, called at a falling edge
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // present one item, hold until accepted, then maybe idle
  task automatic send_item(input logic op, input logic [31:0] col, input logic [2:0] pri,
                           input logic [2:0] lay, input logic [1:0] sel,
                           input logic [1:0] kind, input logic shon, input logic [8:0] y,
                           input logic last);
    int gap;
    opcode_i = op;
    entry_color_i = col;
    entry_priority_i = pri;
    layer_id_i = lay;
    line_select_i = sel;
    shadow_kind_i = kind;
    shadow_on_i = shon;
    line_y_i = y;
    last_entry_i = last;
    push = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    items_sent++;
    @(negedge clk_i);
    gap = 0;
    if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
    if ($urandom_range(0, 60) == 0) gap = $urandom_range(15, 40);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic entry(input logic [31:0] col, input logic [2:0] pri, input logic [2:0] lay,
                       input logic [1:0] sel, input logic [1:0] kind, input logic shon,
                       input logic [8:0] y, input logic last);
    send_item(OP_ENTRY, col, pri, lay, sel, kind, shon, y, last);
  endtask

  function automatic logic [31:0] rand_color();
    logic [31:0] c;
    c = $urandom();
    case ($urandom_range(0, 5))
      0: c[29:24] = 6'h3F;
      1: c[23:0] = 24'h0;
      2: c = {c[31:30], 6'h3F, c[23:0]};
      default: ;
    endcase
    return c;
  endfunction

  // one dot: zero to four entries, the back screen sometimes, then the last one
  task automatic random_dot();
    int          n;
    logic [8:0]  y;
    logic [2:0]  lay;
    n = $urandom_range(0, 4);
    y = ($urandom_range(0, 3) == 0) ? 9'($urandom()) : 9'($urandom_range(0, 7));
    for (int k = 0; k <= n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(OP_LINE_WRITE, rand_color(), 3'($urandom()), 3'($urandom()),
                  2'($urandom()), 2'($urandom()), 1'($urandom()),
                  ($urandom_range(0, 1) == 0) ? 9'($urandom_range(0, 7)) : 9'($urandom()),
                  1'($urandom()));
      end
      lay = ($urandom_range(0, 4) == 0) ? BACK_ID : 3'($urandom());
      entry(rand_color(), ($urandom_range(0, 7) == 0) ? 3'd0 : 3'($urandom_range(1, 7)), lay,
            2'($urandom()), 2'($urandom()), 1'($urandom()), y, k == n);
    end
  endtask

  // stop pushing, wait for all expected dots, then let the pipeline drain
  task automatic settle();
    push = 1'b0;
    while (dots_waiting != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  initial begin
    logic [1:0] modes [5] = '{MODE_TOP, MODE_BOTTOM, MODE_ADD, 2'd3, MODE_TOP};
    items_sent = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    // line memory clearing pass keeps full high
    while (full) @(negedge clk_i);

    // directed: line colours, then each corner of the ranking and shading
    send_item(OP_LINE_WRITE, 32'hBF80_40C0, 3'd0, 3'd0, 2'd1, 2'd0, 1'b0, 9'd3, 1'b1);
    send_item(OP_LINE_WRITE, 32'hFFFF_FFFF, 3'd7, 3'd7, 2'd3, 2'd3, 1'b1, 9'd511, 1'b0);
    send_item(OP_LINE_WRITE, 32'h1234_5678, 3'd0, 3'd0, 2'd0, 2'd0, 1'b0, 9'd3, 1'b0);
    entry(32'h0000_0000, 3'd0, BACK_ID, 2'd0, 2'd0, 1'b0, 9'd0, 1'b1);      // nothing drawn
    entry(32'h3F11_2233, 3'd0, BACK_ID, 2'd0, 2'd0, 1'b0, 9'd0, 1'b1);      // back screen only
    entry(32'h1080_8080, 3'd4, 3'd2, 2'd0, 2'd0, 1'b0, 9'd0, 1'b1);         // one entry, no back
    entry(32'h2000_00FF, 3'd7, 3'd5, 2'd0, 2'd0, 1'b1, 9'd0, 1'b0);         // tie keeps earlier
    entry(32'h3FFF_0000, 3'd7, 3'd5, 2'd0, 2'd0, 1'b1, 9'd0, 1'b0);
    entry(32'hFF00_FF00, 3'd7, 3'd7, 2'd0, 2'd0, 1'b1, 9'd0, 1'b0);         // layer 7 ignored
    entry(32'h3F01_0101, 3'd1, BACK_ID, 2'd0, 2'd0, 1'b1, 9'd0, 1'b0);
    entry(32'h3F02_0202, 3'd0, BACK_ID, 2'd0, 2'd0, 1'b1, 9'd0, 1'b1);      // back replaced
    entry(32'h0A10_2030, 3'd6, 3'd4, 2'd1, 2'd0, 1'b0, 9'd3, 1'b0);         // line table blend
    entry(32'h3F40_4040, 3'd2, 3'd0, 2'd0, 2'd0, 1'b1, 9'd3, 1'b1);
    entry(32'hBF00_0000, 3'd5, 3'd5, 2'd0, SHADOW_MSB, 1'b0, 9'd0, 1'b0);   // sprite, black
    entry(32'h3F60_7080, 3'd3, 3'd1, 2'd0, 2'd0, 1'b1, 9'd0, 1'b1);
    entry(32'h8555_6677, 3'd5, 3'd5, 2'd3, SHADOW_MSB, 1'b0, 9'd511, 1'b0); // sprite self shadow
    entry(32'h3F60_7080, 3'd3, 3'd1, 2'd0, 2'd0, 1'b0, 9'd0, 1'b1);
    entry(32'h3F00_0000, 3'd6, 3'd3, 2'd0, SHADOW_NORMAL, 1'b0, 9'd0, 1'b0); // normal shadow
    entry(32'h3FA0_B0C0, 3'd1, 3'd2, 2'd0, 2'd0, 1'b1, 9'd0, 1'b1);
    entry(32'h0012_3456, 3'd2, 3'd0, 2'd2, 2'd3, 1'b1, 9'd100, 1'b1);       // kind 3 as none
    settle();

    // random dots under several register settings
    for (int ph = 0; ph < 5; ph++) begin
      push = 1'b0;
      reg_write({REG_BLEND_MODE, 2'b00}, {30'($urandom()), modes[ph]});
      reg_write({REG_SPRITE_WIN, 2'b00}, {31'($urandom()), 1'(ph % 2)});
      while (items_sent < 20 + 130 * (ph + 1)) random_dot();
      settle();
    end

    push = 1'b0;
    settle();
    if (fail_count == 0 && dots_waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
